/* rtl/assert_macros.svh */
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: condition does not hold");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/gmhp_pkg.sv */
`default_nettype none

package gmhp_pkg;

  localparam logic [7:0] MAGIC0 = 8'h1F;
  localparam logic [7:0] MAGIC1 = 8'h8B;
  localparam logic [7:0] CM_DEFLATE = 8'd8;
  localparam logic [7:0] RESERVED_MASK = 8'hE0;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int unsigned MIN_LEN = 18;
  localparam int unsigned TRAILER_LEN = 8;
  localparam int unsigned TAIL_DEPTH = 8;
  localparam int unsigned IDX_MAGIC0 = 0;
  localparam int unsigned IDX_MAGIC1 = 1;
  localparam int unsigned IDX_METHOD = 2;
  localparam int unsigned IDX_FLAGS = 3;
  localparam int unsigned IDX_FIXED_LAST = 9;

  localparam int unsigned FL_HCRC_BIT = 1;
  localparam int unsigned FL_EXTRA_BIT = 2;
  localparam int unsigned FL_NAME_BIT = 3;
  localparam int unsigned FL_COMMENT_BIT = 4;

  localparam int unsigned LVL_EXTRA = 0;
  localparam int unsigned LVL_NAME = 1;
  localparam int unsigned LVL_COMMENT = 2;
  localparam int unsigned LVL_HCRC = 3;
  localparam int unsigned LVL_END = 4;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLEN_LO = 4'd1,
    PH_XLEN_HI = 4'd2,
    PH_EXTRA   = 4'd3,
    PH_NAME    = 4'd4,
    PH_COMMENT = 4'd5,
    PH_HCRC_LO = 4'd6,
    PH_HCRC_HI = 4'd7,
    PH_DONE    = 4'd8,
    PH_HALT    = 4'd9
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_SHORT         = 4'd1,
    ST_MAGIC         = 4'd2,
    ST_METHOD        = 4'd3,
    ST_RESERVED      = 4'd4,
    ST_EXTRA         = 4'd5,
    ST_NAME          = 4'd6,
    ST_COMMENT       = 4'd7,
    ST_HCRC_OVERRUN  = 4'd8,
    ST_HCRC_MISMATCH = 4'd9,
    ST_TRUNCATED     = 4'd10
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } stage_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [7:0]  header_flags;
    logic [31:0] expected_crc;
    logic [31:0] expected_size;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Picks the next optional field at or after the given level.
  function automatic phase_t next_field(input int unsigned level, input logic [7:0] flags);
    phase_t ph;
    if (level <= LVL_EXTRA && flags[FL_EXTRA_BIT]) begin
      ph = PH_XLEN_LO;
    end else if (level <= LVL_NAME && flags[FL_NAME_BIT]) begin
      ph = PH_NAME;
    end else if (level <= LVL_COMMENT && flags[FL_COMMENT_BIT]) begin
      ph = PH_COMMENT;
    end else if (level <= LVL_HCRC && flags[FL_HCRC_BIT]) begin
      ph = PH_HCRC_LO;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

endpackage

`default_nettype wire

/* rtl/gmhp_in_if.sv */
`default_nettype none

interface gmhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/gmhp_out_if.sv */
`default_nettype none

interface gmhp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] payload_offset;
  logic [31:0] payload_length;
  logic [7:0]  header_flags;
  logic [31:0] expected_crc;
  logic [31:0] expected_size;

  modport source(output valid, output status, output payload_offset, output payload_length,
                 output header_flags, output expected_crc, output expected_size,
                 input ready);
  modport sink(input valid, input status, input payload_offset, input payload_length,
               input header_flags, input expected_crc, input expected_size,
               output ready);
endinterface

`default_nettype wire

/* rtl/gmhp_in_stage.sv */
`default_nettype none

module gmhp_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  gmhp_in_if.sink              stream,
  input  wire logic            advance,
  output gmhp_pkg::stage_t     stage
);

  logic       valid;
  logic       valid_next;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       accept;

  assign stream.ready = !valid || advance;
  assign accept = stream.valid && stream.ready;

  always_comb begin
    if (accept) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_byte <= stream.data_byte;
      last_byte <= stream.last_byte;
    end
  end

  assign stage = '{valid: valid, data_byte: data_byte, last_byte: last_byte};

endmodule

`default_nettype wire

/* rtl/gmhp_parser.sv */
`default_nettype none

module gmhp_parser #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gmhp_pkg::stage_t stage,
  input  wire logic             advance,
  output gmhp_pkg::result_t     res
);

  localparam int unsigned LW = LENGTH_WIDTH;
  localparam logic [LW-1:0] LEN_MAX = '1;

  logic [LW-1:0]     byte_count;
  logic [LW-1:0]     byte_count_next;
  gmhp_pkg::phase_t  parse_phase;
  gmhp_pkg::phase_t  parse_phase_next;
  logic [7:0]        flag_store;
  logic [7:0]        flag_store_next;
  logic [16:0]       extra_remaining;
  logic [16:0]       extra_remaining_next;
  logic [31:0]       header_crc_reg;
  logic [31:0]       header_crc_reg_next;
  logic [15:0]       stored_hcrc;
  logic [15:0]       stored_hcrc_next;
  gmhp_pkg::status_t first_error;
  gmhp_pkg::status_t first_error_next;
  logic [LW:0]       header_end;
  logic [LW:0]       header_end_next;
  logic [7:0]        tail_bytes [gmhp_pkg::TAIL_DEPTH];
  logic [7:0]        tail_bytes_next [gmhp_pkg::TAIL_DEPTH];

  logic [7:0]        b;
  logic [LW:0]       end_pos;
  logic              do_enter;
  int unsigned       enter_level;
  logic [LW+1:0]     header_need;
  logic [LW:0]       plen_full;
  logic [63:0]       off_wide;
  logic [63:0]       plen_wide;

  assign b = stage.data_byte;
  assign end_pos = {1'b0, byte_count} + (LW+1)'(1);

  always_comb begin
    byte_count_next = (byte_count < LEN_MAX) ? byte_count + LW'(1) : byte_count;
    parse_phase_next = parse_phase;
    flag_store_next = flag_store;
    extra_remaining_next = extra_remaining;
    header_crc_reg_next = header_crc_reg;
    stored_hcrc_next = stored_hcrc;
    first_error_next = first_error;
    header_end_next = header_end;
    do_enter = 1'b0;
    enter_level = gmhp_pkg::LVL_EXTRA;

    if (parse_phase < gmhp_pkg::PH_HCRC_LO) begin
      header_crc_reg_next = gmhp_pkg::crc_byte(header_crc_reg, b);
    end

    unique case (parse_phase)
      gmhp_pkg::PH_FIXED: begin
        priority if (byte_count == LW'(gmhp_pkg::IDX_MAGIC0) && b != gmhp_pkg::MAGIC0) begin
          first_error_next = gmhp_pkg::ST_MAGIC;
          parse_phase_next = gmhp_pkg::PH_HALT;
        end else if (byte_count == LW'(gmhp_pkg::IDX_MAGIC1) && b != gmhp_pkg::MAGIC1) begin
          first_error_next = gmhp_pkg::ST_MAGIC;
          parse_phase_next = gmhp_pkg::PH_HALT;
        end else if (byte_count == LW'(gmhp_pkg::IDX_METHOD) && b != gmhp_pkg::CM_DEFLATE) begin
          first_error_next = gmhp_pkg::ST_METHOD;
          parse_phase_next = gmhp_pkg::PH_HALT;
        end else if (byte_count == LW'(gmhp_pkg::IDX_FLAGS)) begin
          flag_store_next = b;
          if ((b & gmhp_pkg::RESERVED_MASK) != 8'd0) begin
            first_error_next = gmhp_pkg::ST_RESERVED;
            parse_phase_next = gmhp_pkg::PH_HALT;
          end
        end else if (byte_count >= LW'(gmhp_pkg::IDX_FIXED_LAST)) begin
          do_enter = 1'b1;
          enter_level = gmhp_pkg::LVL_EXTRA;
        end else begin
          parse_phase_next = parse_phase;
        end
      end
      gmhp_pkg::PH_XLEN_LO: begin
        extra_remaining_next = {9'd0, b};
        parse_phase_next = gmhp_pkg::PH_XLEN_HI;
      end
      gmhp_pkg::PH_XLEN_HI: begin
        extra_remaining_next = extra_remaining | {1'b0, b, 8'd0};
        if (extra_remaining_next == 17'd0) begin
          do_enter = 1'b1;
          enter_level = gmhp_pkg::LVL_NAME;
        end else begin
          parse_phase_next = gmhp_pkg::PH_EXTRA;
        end
      end
      gmhp_pkg::PH_EXTRA: begin
        extra_remaining_next = extra_remaining - 17'd1;
        if (extra_remaining_next == 17'd0) begin
          do_enter = 1'b1;
          enter_level = gmhp_pkg::LVL_NAME;
        end
      end
      gmhp_pkg::PH_NAME: begin
        if (b == 8'd0) begin
          do_enter = 1'b1;
          enter_level = gmhp_pkg::LVL_COMMENT;
        end
      end
      gmhp_pkg::PH_COMMENT: begin
        if (b == 8'd0) begin
          do_enter = 1'b1;
          enter_level = gmhp_pkg::LVL_HCRC;
        end
      end
      gmhp_pkg::PH_HCRC_LO: begin
        stored_hcrc_next = {8'd0, b};
        parse_phase_next = gmhp_pkg::PH_HCRC_HI;
      end
      gmhp_pkg::PH_HCRC_HI: begin
        stored_hcrc_next = {b, stored_hcrc[7:0]};
        if (stored_hcrc_next != ~header_crc_reg[15:0]) begin
          first_error_next = gmhp_pkg::ST_HCRC_MISMATCH;
          parse_phase_next = gmhp_pkg::PH_HALT;
        end else begin
          do_enter = 1'b1;
          enter_level = gmhp_pkg::LVL_END;
        end
      end
      default: begin
        parse_phase_next = parse_phase;
      end
    endcase

    if (do_enter) begin
      parse_phase_next = gmhp_pkg::next_field(enter_level, flag_store);
      if (parse_phase_next == gmhp_pkg::PH_DONE) begin
        header_end_next = end_pos;
      end
    end

    for (int i = 0; i < gmhp_pkg::TAIL_DEPTH - 1; i++) begin
      tail_bytes_next[i] = tail_bytes[i+1];
    end
    tail_bytes_next[gmhp_pkg::TAIL_DEPTH-1] = b;
  end

  assign header_need = {1'b0, header_end_next} + (LW+2)'(gmhp_pkg::TRAILER_LEN);
  assign plen_full = {1'b0, byte_count_next} - header_end_next
                   - (LW+1)'(gmhp_pkg::TRAILER_LEN);
  assign off_wide = 64'(header_end_next);
  assign plen_wide = 64'(plen_full);

  always_comb begin
    res.payload_offset = 32'd0;
    res.payload_length = 32'd0;
    if (byte_count_next < LW'(gmhp_pkg::MIN_LEN)) begin
      res.status = gmhp_pkg::ST_SHORT;
    end else if (first_error_next != gmhp_pkg::ST_OK) begin
      res.status = first_error_next;
    end else begin
      unique case (parse_phase_next)
        gmhp_pkg::PH_XLEN_LO, gmhp_pkg::PH_XLEN_HI, gmhp_pkg::PH_EXTRA: begin
          res.status = gmhp_pkg::ST_EXTRA;
        end
        gmhp_pkg::PH_NAME: begin
          res.status = gmhp_pkg::ST_NAME;
        end
        gmhp_pkg::PH_COMMENT: begin
          res.status = gmhp_pkg::ST_COMMENT;
        end
        gmhp_pkg::PH_HCRC_LO, gmhp_pkg::PH_HCRC_HI: begin
          res.status = gmhp_pkg::ST_HCRC_OVERRUN;
        end
        gmhp_pkg::PH_DONE: begin
          if (header_need > {2'b0, byte_count_next}) begin
            res.status = gmhp_pkg::ST_TRUNCATED;
          end else begin
            res.status = gmhp_pkg::ST_OK;
            res.payload_offset = off_wide[31:0];
            res.payload_length = plen_wide[31:0];
          end
        end
        default: begin
          res.status = gmhp_pkg::ST_TRUNCATED;
        end
      endcase
    end
    res.header_flags = flag_store_next;
    res.expected_crc = {tail_bytes_next[3], tail_bytes_next[2],
                        tail_bytes_next[1], tail_bytes_next[0]};
    res.expected_size = {tail_bytes_next[7], tail_bytes_next[6],
                         tail_bytes_next[5], tail_bytes_next[4]};
  end

  // The last byte of a buffer returns every register to its reset value.
  always_ff @(posedge clk) begin
    if (rst || (advance && stage.last_byte)) begin
      byte_count <= '0;
      parse_phase <= gmhp_pkg::PH_FIXED;
      flag_store <= 8'd0;
      extra_remaining <= 17'd0;
      header_crc_reg <= gmhp_pkg::CRC_INIT;
      stored_hcrc <= 16'd0;
      first_error <= gmhp_pkg::ST_OK;
      header_end <= '0;
      for (int i = 0; i < gmhp_pkg::TAIL_DEPTH; i++) begin
        tail_bytes[i] <= 8'd0;
      end
    end else if (advance) begin
      byte_count <= byte_count_next;
      parse_phase <= parse_phase_next;
      flag_store <= flag_store_next;
      extra_remaining <= extra_remaining_next;
      header_crc_reg <= header_crc_reg_next;
      stored_hcrc <= stored_hcrc_next;
      first_error <= first_error_next;
      header_end <= header_end_next;
      for (int i = 0; i < gmhp_pkg::TAIL_DEPTH; i++) begin
        tail_bytes[i] <= tail_bytes_next[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/gmhp_out_reg.sv */
`default_nettype none

module gmhp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire gmhp_pkg::result_t res,
  output logic                   slot_free,
  gmhp_out_if.source             result
);

  logic              valid;
  logic              valid_next;
  gmhp_pkg::result_t held;

  assign slot_free = !valid || result.ready;

  always_comb begin
    if (load) begin
      valid_next = 1'b1;
    end else if (result.ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.valid = valid;
  assign result.status = held.status;
  assign result.payload_offset = held.payload_offset;
  assign result.payload_length = held.payload_length;
  assign result.header_flags = held.header_flags;
  assign result.expected_crc = held.expected_crc;
  assign result.expected_size = held.expected_size;

endmodule

`default_nettype wire

/* rtl/gzip_member_header_parser.sv */
// gzip member header parser.
// The stream channel carries one byte of a gzip buffer per transfer, with
// last_byte marking the final byte. The result channel carries one transfer
// per buffer: status, deflate payload offset and length, the flag byte and
// the trailer CRC and size.
// Each byte lands in an input register and is parsed from there; when the
// last byte of a buffer is parsed, the result is loaded into the output
// register. One byte is taken every cycle, except that the last byte of a
// buffer waits in the input register while the output register is full.
// When the receiver stalls, the result is held and the next buffer keeps
// streaming until its own last byte waits in the input register.
// Synchronous reset clears both handshake registers and returns the parser
// to the start of a header, with the CRC at its initial value and the
// trailer bytes at zero. The parser returns to the same state after each
// last byte.
`default_nettype none
`include "assert_macros.svh"

module gzip_member_header_parser #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  gmhp_in_if.sink    stream,
  gmhp_out_if.source result
);

  gmhp_pkg::stage_t  stage;
  gmhp_pkg::result_t res;
  logic              slot_free;
  logic              advance;
  logic              load_result;
  logic              last_waiting;
  logic              result_error;
  logic              payload_clear;

  assign advance = stage.valid && (!stage.last_byte || slot_free);
  assign load_result = advance && stage.last_byte;
  assign last_waiting = stage.valid && stage.last_byte;
  assign result_error = result.valid && result.status != gmhp_pkg::ST_OK;
  assign payload_clear = result.payload_offset == 32'd0 && result.payload_length == 32'd0;

  gmhp_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .advance (advance),
    .stage   (stage)
  );

  gmhp_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .res     (res)
  );

  gmhp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (load_result),
    .res       (res),
    .slot_free (slot_free),
    .result    (result)
  );

  `ASSERT_NEXT(a_last_held_on_stall, clk, rst, last_waiting && !slot_free, last_waiting)
  `ASSERT_IMPLIES(a_load_into_free_slot, clk, rst, load_result, slot_free)
  `ASSERT_IMPLIES(a_error_zero_payload, clk, rst, result_error, payload_clear)

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 1160;
  localparam int PHASE_BYTES = 800;
  localparam int HOLD_AT_BYTES = 1700;
  localparam int HOLD_CYCLES = 600;
  localparam int ROW_COUNT = 19;
  localparam int NONE = -1;

  typedef struct {
    logic [7:0]        flags;
    int                xlen;
    int                name_len;
    int                cmt_len;
    int                body_len;
    bit                crc_ok;
    int                poke_at;
    logic [7:0]        poke_val;
    int                cut;
    bit                typed;
    gmhp_pkg::status_t status;
  } row_t;

  logic clk;
  logic rst;

  gmhp_in_if stream_ch();
  gmhp_out_if result_ch();

  gzip_member_header_parser i_dut (
    .clk(clk),
    .rst(rst),
    .stream(stream_ch),
    .result(result_ch)
  );

  // Parser state mirrored from the byte stream.
  logic [31:0]       m_count;
  gmhp_pkg::phase_t  m_phase;
  logic [7:0]        m_flags;
  logic [16:0]       m_extra_left;
  logic [31:0]       m_crc;
  logic [15:0]       m_hcrc;
  gmhp_pkg::status_t m_err;
  logic [31:0]       m_hdr_end;
  logic [7:0]        m_tail [8];

  gmhp_pkg::result_t member_results_due [$];
  logic [7:0]        member_bytes [$];
  int                bytes_in;
  int                failures;
  int unsigned       cycle_count = 0;

  row_t directed_rows [ROW_COUNT] = '{
    '{8'h00, 0, 0, 0, 0, 1'b1, NONE, 8'h00, NONE, 1'b1, gmhp_pkg::ST_OK},
    '{8'h00, 0, 0, 0, 0, 1'b1, NONE, 8'h00, 1, 1'b1, gmhp_pkg::ST_SHORT},
    '{8'h00, 0, 0, 0, 0, 1'b1, NONE, 8'h00, 17, 1'b1, gmhp_pkg::ST_SHORT},
    '{8'h00, 0, 0, 0, 4, 1'b1, 0, 8'h1E, NONE, 1'b1, gmhp_pkg::ST_MAGIC},
    '{8'h00, 0, 0, 0, 4, 1'b1, 1, 8'h8A, NONE, 1'b1, gmhp_pkg::ST_MAGIC},
    '{8'h00, 0, 0, 0, 4, 1'b1, 2, 8'h07, NONE, 1'b1, gmhp_pkg::ST_METHOD},
    '{8'hFF, 2, 2, 2, 2, 1'b1, NONE, 8'h00, NONE, 1'b1, gmhp_pkg::ST_RESERVED},
    '{8'h20, 0, 0, 0, 3, 1'b1, NONE, 8'h00, NONE, 1'b1, gmhp_pkg::ST_RESERVED},
    '{8'h1F, 3, 4, 5, 6, 1'b1, NONE, 8'h00, NONE, 1'b0, gmhp_pkg::ST_OK},
    '{8'h02, 0, 0, 0, 5, 1'b0, NONE, 8'h00, NONE, 1'b1, gmhp_pkg::ST_HCRC_MISMATCH},
    '{8'h04, 65535, 0, 0, 0, 1'b1, NONE, 8'h00, 30, 1'b1, gmhp_pkg::ST_EXTRA},
    '{8'h08, 0, 40, 0, 0, 1'b1, NONE, 8'h00, 30, 1'b1, gmhp_pkg::ST_NAME},
    '{8'h10, 0, 0, 40, 0, 1'b1, NONE, 8'h00, 30, 1'b1, gmhp_pkg::ST_COMMENT},
    '{8'h0A, 0, 16, 0, 0, 1'b1, NONE, 8'h00, 28, 1'b1, gmhp_pkg::ST_HCRC_OVERRUN},
    '{8'h08, 0, 10, 0, 0, 1'b1, NONE, 8'h00, 25, 1'b1, gmhp_pkg::ST_TRUNCATED},
    '{8'h04, 0, 0, 0, 2, 1'b1, NONE, 8'h00, NONE, 1'b1, gmhp_pkg::ST_OK},
    '{8'h04, 257, 0, 0, 3, 1'b1, NONE, 8'h00, NONE, 1'b0, gmhp_pkg::ST_OK},
    '{8'h00, 0, 0, 0, 0, 1'b1, 0, 8'h00, 5, 1'b1, gmhp_pkg::ST_SHORT},
    '{8'hE0, 0, 0, 0, 2, 1'b1, 1, 8'h00, NONE, 1'b1, gmhp_pkg::ST_MAGIC}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ gmhp_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    failures++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  function automatic int idle_pct(input bit is_sender);
    if (bytes_in < PHASE_BYTES) begin
      return is_sender ? 34 : 80;
    end else if (bytes_in < 2 * PHASE_BYTES) begin
      return is_sender ? 80 : 34;
    end
    return 0;
  endfunction

  function automatic void clear_member_state();
    m_count = '0;
    m_phase = gmhp_pkg::PH_FIXED;
    m_flags = '0;
    m_extra_left = '0;
    m_crc = gmhp_pkg::CRC_INIT;
    m_hcrc = '0;
    m_err = gmhp_pkg::ST_OK;
    m_hdr_end = '0;
    foreach (m_tail[i]) m_tail[i] = '0;
  endfunction

  function automatic void halt_parse(input gmhp_pkg::status_t code);
    m_err = code;
    m_phase = gmhp_pkg::PH_HALT;
  endfunction

  function automatic void pick_field(input int unsigned level, input logic [31:0] end_off);
    if (level <= gmhp_pkg::LVL_EXTRA && m_flags[gmhp_pkg::FL_EXTRA_BIT]) begin
      m_phase = gmhp_pkg::PH_XLEN_LO;
    end else if (level <= gmhp_pkg::LVL_NAME && m_flags[gmhp_pkg::FL_NAME_BIT]) begin
      m_phase = gmhp_pkg::PH_NAME;
    end else if (level <= gmhp_pkg::LVL_COMMENT && m_flags[gmhp_pkg::FL_COMMENT_BIT]) begin
      m_phase = gmhp_pkg::PH_COMMENT;
    end else if (level <= gmhp_pkg::LVL_HCRC && m_flags[gmhp_pkg::FL_HCRC_BIT]) begin
      m_phase = gmhp_pkg::PH_HCRC_LO;
    end else begin
      m_phase = gmhp_pkg::PH_DONE;
      m_hdr_end = end_off;
    end
  endfunction

  task automatic member_step(input logic [7:0] b, input bit last, output bit done,
                             output gmhp_pkg::result_t res);
    logic [31:0]       end_off;
    gmhp_pkg::status_t st;
    end_off = m_count + 1;
    done = 1'b0;
    res = '0;
    if (m_phase < gmhp_pkg::PH_HCRC_LO) m_crc = crc32_update(m_crc, b);
    case (m_phase)
      gmhp_pkg::PH_FIXED: begin
        if (m_count == gmhp_pkg::IDX_MAGIC0 && b != gmhp_pkg::MAGIC0) begin
          halt_parse(gmhp_pkg::ST_MAGIC);
        end else if (m_count == gmhp_pkg::IDX_MAGIC1 && b != gmhp_pkg::MAGIC1) begin
          halt_parse(gmhp_pkg::ST_MAGIC);
        end else if (m_count == gmhp_pkg::IDX_METHOD && b != gmhp_pkg::CM_DEFLATE) begin
          halt_parse(gmhp_pkg::ST_METHOD);
        end else begin
          if (m_count == gmhp_pkg::IDX_FLAGS) m_flags = b;
          if (m_count == gmhp_pkg::IDX_FLAGS && (b & gmhp_pkg::RESERVED_MASK) != 0) begin
            halt_parse(gmhp_pkg::ST_RESERVED);
          end else if (m_count >= gmhp_pkg::IDX_FIXED_LAST) begin
            pick_field(gmhp_pkg::LVL_EXTRA, end_off);
          end
        end
      end
      gmhp_pkg::PH_XLEN_LO: begin
        m_extra_left = {9'b0, b};
        m_phase = gmhp_pkg::PH_XLEN_HI;
      end
      gmhp_pkg::PH_XLEN_HI: begin
        m_extra_left = m_extra_left | {1'b0, b, 8'b0};
        if (m_extra_left == 0) pick_field(gmhp_pkg::LVL_NAME, end_off);
        else m_phase = gmhp_pkg::PH_EXTRA;
      end
      gmhp_pkg::PH_EXTRA: begin
        m_extra_left = m_extra_left - 17'd1;
        if (m_extra_left == 0) pick_field(gmhp_pkg::LVL_NAME, end_off);
      end
      gmhp_pkg::PH_NAME: if (b == 0) pick_field(gmhp_pkg::LVL_COMMENT, end_off);
      gmhp_pkg::PH_COMMENT: if (b == 0) pick_field(gmhp_pkg::LVL_HCRC, end_off);
      gmhp_pkg::PH_HCRC_LO: begin
        m_hcrc = {8'b0, b};
        m_phase = gmhp_pkg::PH_HCRC_HI;
      end
      gmhp_pkg::PH_HCRC_HI: begin
        m_hcrc[15:8] = b;
        if (m_hcrc != ~m_crc[15:0]) halt_parse(gmhp_pkg::ST_HCRC_MISMATCH);
        else pick_field(gmhp_pkg::LVL_END, end_off);
      end
      default: ;
    endcase
    for (int i = 0; i < 7; i++) m_tail[i] = m_tail[i + 1];
    m_tail[7] = b;
    if (m_count != '1) m_count++;
    if (last) begin
      if (m_count < gmhp_pkg::MIN_LEN) begin
        st = gmhp_pkg::ST_SHORT;
      end else if (m_err != gmhp_pkg::ST_OK) begin
        st = m_err;
      end else begin
        case (m_phase)
          gmhp_pkg::PH_XLEN_LO, gmhp_pkg::PH_XLEN_HI, gmhp_pkg::PH_EXTRA: begin
            st = gmhp_pkg::ST_EXTRA;
          end
          gmhp_pkg::PH_NAME: st = gmhp_pkg::ST_NAME;
          gmhp_pkg::PH_COMMENT: st = gmhp_pkg::ST_COMMENT;
          gmhp_pkg::PH_HCRC_LO, gmhp_pkg::PH_HCRC_HI: st = gmhp_pkg::ST_HCRC_OVERRUN;
          gmhp_pkg::PH_DONE: begin
            if ({32'b0, m_hdr_end} + 64'(gmhp_pkg::TRAILER_LEN) > {32'b0, m_count}) begin
              st = gmhp_pkg::ST_TRUNCATED;
            end else begin
              st = gmhp_pkg::ST_OK;
              res.payload_offset = m_hdr_end;
              res.payload_length = m_count - m_hdr_end - gmhp_pkg::TRAILER_LEN;
            end
          end
          default: st = gmhp_pkg::ST_TRUNCATED;
        endcase
      end
      res.status = st;
      res.header_flags = m_flags;
      res.expected_crc = {m_tail[3], m_tail[2], m_tail[1], m_tail[0]};
      res.expected_size = {m_tail[7], m_tail[6], m_tail[5], m_tail[4]};
      done = 1'b1;
      clear_member_state();
    end
  endtask

  task automatic build_member(input logic [7:0] flg, input int xlen, input int name_len,
                              input int cmt_len, input int body_len, input bit crc_ok);
    logic [31:0] crc;
    member_bytes.delete();
    member_bytes.push_back(gmhp_pkg::MAGIC0);
    member_bytes.push_back(gmhp_pkg::MAGIC1);
    member_bytes.push_back(gmhp_pkg::CM_DEFLATE);
    member_bytes.push_back(flg);
    repeat (6) member_bytes.push_back(8'($urandom));
    if (flg[gmhp_pkg::FL_EXTRA_BIT]) begin
      member_bytes.push_back(xlen[7:0]);
      member_bytes.push_back(xlen[15:8]);
      repeat (xlen) member_bytes.push_back(8'($urandom));
    end
    if (flg[gmhp_pkg::FL_NAME_BIT]) begin
      repeat (name_len) member_bytes.push_back(8'($urandom_range(1, 255)));
      member_bytes.push_back(8'h00);
    end
    if (flg[gmhp_pkg::FL_COMMENT_BIT]) begin
      repeat (cmt_len) member_bytes.push_back(8'($urandom_range(1, 255)));
      member_bytes.push_back(8'h00);
    end
    if (flg[gmhp_pkg::FL_HCRC_BIT]) begin
      crc = gmhp_pkg::CRC_INIT;
      foreach (member_bytes[i]) crc = crc32_update(crc, member_bytes[i]);
      crc = ~crc;
      member_bytes.push_back(crc[7:0] ^ (crc_ok ? 8'h00 : 8'($urandom_range(1, 255))));
      member_bytes.push_back(crc[15:8]);
    end
    repeat (body_len + gmhp_pkg::TRAILER_LEN) member_bytes.push_back(8'($urandom));
  endtask

  task automatic send_member(input bit typed, input gmhp_pkg::status_t typed_status);
    int                idx;
    bit                holding;
    bit                done;
    gmhp_pkg::result_t res;
    idx = 0;
    holding = 1'b0;
    while (idx < member_bytes.size()) begin
      @(negedge clk);
      if (!holding) begin
        if ($urandom_range(0, 99) < idle_pct(1'b1)) begin
          stream_ch.valid <= 1'b0;
        end else begin
          stream_ch.valid <= 1'b1;
          stream_ch.data_byte <= member_bytes[idx];
          stream_ch.last_byte <= (idx == member_bytes.size() - 1);
          holding = 1'b1;
        end
      end
      @(posedge clk);
      if (stream_ch.valid && stream_ch.ready) begin
        member_step(stream_ch.data_byte, stream_ch.last_byte, done, res);
        if (done) begin
          if (typed) res.status = typed_status;
          member_results_due.push_back(res);
        end
        idx++;
        bytes_in++;
        holding = 1'b0;
      end
    end
  endtask

  initial begin
    int                stall_left;
    bit                held;
    gmhp_pkg::result_t want;
    stall_left = 0;
    held = 1'b0;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!held && bytes_in >= HOLD_AT_BYTES) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        if (member_results_due.size() == 0) begin
          report_mismatch("result transfer with no buffer outstanding");
        end else begin
          want = member_results_due.pop_front();
          check_field("status", result_ch.status, want.status);
          check_field("payload_offset", result_ch.payload_offset, want.payload_offset);
          check_field("payload_length", result_ch.payload_length, want.payload_length);
          check_field("header_flags", result_ch.header_flags, want.header_flags);
          check_field("expected_crc", result_ch.expected_crc, want.expected_crc);
          check_field("expected_size", result_ch.expected_size, want.expected_size);
        end
      end
    end
  end

  initial begin
    logic [7:0] flg;
    int         pick;
    int         start;
    rst = 1'b1;
    stream_ch.valid = 1'b0;
    stream_ch.data_byte = 8'h00;
    stream_ch.last_byte = 1'b0;
    bytes_in = 0;
    failures = 0;
    clear_member_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      build_member(directed_rows[r].flags, directed_rows[r].xlen, directed_rows[r].name_len,
                   directed_rows[r].cmt_len, directed_rows[r].body_len,
                   directed_rows[r].crc_ok);
      if (directed_rows[r].poke_at != NONE) begin
        member_bytes[directed_rows[r].poke_at] = directed_rows[r].poke_val;
      end
      if (directed_rows[r].cut != NONE) begin
        while (member_bytes.size() > directed_rows[r].cut) void'(member_bytes.pop_back());
      end
      send_member(directed_rows[r].typed, directed_rows[r].status);
    end

    // Mostly well-formed members with random content; the rest are cut short,
    // have a byte overwritten, set reserved flag bits or carry a bad header CRC.
    start = bytes_in;
    while (bytes_in - start < RANDOM_BYTES) begin
      flg = 8'($urandom);
      if ($urandom_range(0, 99) >= 4) flg = flg & ~gmhp_pkg::RESERVED_MASK;
      build_member(flg, $urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 8),
                   $urandom_range(0, 24), $urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        member_bytes[$urandom_range(0, 3)] = 8'($urandom);
      end else if (pick >= 80) begin
        member_bytes[$urandom_range(0, member_bytes.size() - 1)] = 8'($urandom);
      end else if (pick >= 70) begin
        pick = $urandom_range(1, member_bytes.size());
        while (member_bytes.size() > pick) void'(member_bytes.pop_back());
      end
      send_member(1'b0, gmhp_pkg::ST_OK);
    end

    @(negedge clk);
    stream_ch.valid <= 1'b0;
    while (member_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
